// File: hdl/range_sum_segment_tree_macros.svh
// Assertion macros for the range-sum segment tree RTL.
`ifndef RANGE_SUM_SEGMENT_TREE_MACROS_SVH
`define RANGE_SUM_SEGMENT_TREE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, switched off while reset is high.
`define RSST_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, switched off while reset is high.
`define RSST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RSST_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define RSST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: hdl/rsst_pkg.sv
// Package with the sizes, types and state codes of the range-sum segment tree.
`timescale 1ns / 1ps
package rsst_pkg;

   localparam int ELEMENTS = 1024;
   localparam int IDX_W    = 10;
   localparam int SUM_W    = 32;
   localparam int NODES    = 2 * ELEMENTS;
   localparam int NODE_W   = $clog2(NODES);
   localparam int PTR_W    = $clog2(NODES + 1);

   typedef logic [NODE_W-1:0] node_addr_type;
   typedef logic [PTR_W-1:0]  ptr_type;

   localparam node_addr_type NODE_LAST = node_addr_type'(NODES - 1);
   localparam node_addr_type NODE_ONE  = node_addr_type'(1);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_W_UP,
      ST_Q_LO,
      ST_Q_HI,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               wr_en;
      node_addr_type      wr_addr;
      logic [SUM_W-1:0]   wr_data;
      logic               rd_en;
      node_addr_type      rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic                    valid;
      logic signed [SUM_W-1:0] sum;
      logic                    bad;
   } result_type;

endpackage

// File: hdl/rsst_node_ram.sv
// Node store of the tree: one write port and one registered read port.
`timescale 1ns / 1ps
module rsst_node_ram (
   input  logic                        clock,
   input  rsst_pkg::mem_req_type       mem_req,
   output logic [rsst_pkg::SUM_W-1:0]  rd_data_ff
);
   import rsst_pkg::*;

   logic [SUM_W-1:0] mem [NODES];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

endmodule

// File: hdl/rsst_seq.sv
// Sequencer of the tree walk with its shared accumulating adder.
`timescale 1ns / 1ps
`include "range_sum_segment_tree_macros.svh"
module rsst_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic [rsst_pkg::IDX_W-1:0]        req_index_lo,
   input  logic [rsst_pkg::IDX_W-1:0]        req_index_hi,
   input  logic signed [rsst_pkg::SUM_W-1:0] req_value,
   output rsst_pkg::mem_req_type             mem_req,
   input  logic [rsst_pkg::SUM_W-1:0]        mem_rd_data,
   input  logic                              out_free,
   output rsst_pkg::result_type              result
);
   import rsst_pkg::*;

   state_type        state_ff, state_in;
   node_addr_type    clr_ff, clr_in;
   node_addr_type    p_ff, p_in;
   ptr_type          a_ff, a_in;
   ptr_type          b_ff, b_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic             pend_ff, pend_in;
   logic             bad_ff, bad_in;

   logic             accept;
   logic             write_ok;
   logic             reversed;
   int               lo_int;
   int               hi_int;
   int               hi_clamp;
   node_addr_type    leaf;
   node_addr_type    parent;
   logic             parent_is_root;
   logic             a_lt_b;
   logic [SUM_W-1:0] add_b;
   logic [SUM_W-1:0] sum_out;

   assign accept         = req_valid && !req_stall;
   assign lo_int         = int'(req_index_lo);
   assign hi_int         = int'(req_index_hi);
   assign hi_clamp       = (hi_int >= ELEMENTS) ? (ELEMENTS - 1) : hi_int;
   assign write_ok       = lo_int < ELEMENTS;
   assign reversed       = req_index_lo > req_index_hi;
   assign leaf           = node_addr_type'(lo_int + ELEMENTS);
   assign parent         = p_ff >> 1;
   assign parent_is_root = parent == NODE_ONE;
   assign a_lt_b         = a_ff < b_ff;

   // The one adder: on the way up it adds the sibling, in a query a pending node.
   assign add_b   = ((state_ff == ST_W_UP) || pend_ff) ? mem_rd_data : '0;
   assign sum_out = acc_ff + add_b;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == NODE_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_WRITE) begin
                  state_in = write_ok ? ST_W_UP : ST_IDLE;
               end else begin
                  state_in = reversed ? ST_DONE : ST_Q_LO;
               end
            end
         end
         ST_W_UP: begin
            if (parent_is_root) state_in = ST_IDLE;
         end
         ST_Q_LO: begin
            state_in = a_lt_b ? ST_Q_HI : ST_DONE;
         end
         ST_Q_HI: begin
            state_in = ST_Q_LO;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_stall    = state_ff != ST_IDLE;
      mem_req      = '0;
      result.valid = state_ff == ST_DONE;
      result.sum   = acc_ff;
      result.bad   = bad_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_ff;
         end
         ST_IDLE: begin
            if (accept && (req_op == OP_WRITE) && write_ok) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = leaf;
               mem_req.wr_data = req_value;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = leaf ^ NODE_ONE;
            end
         end
         ST_W_UP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = parent;
            mem_req.wr_data = sum_out;
            if (!parent_is_root) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = parent ^ NODE_ONE;
            end
         end
         ST_Q_LO: begin
            if (a_lt_b && a_ff[0]) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = a_ff[NODE_W-1:0];
            end
         end
         ST_Q_HI: begin
            if (b_ff[0]) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = {b_ff[NODE_W-1:1], 1'b0};
            end
         end
         default: begin
            mem_req = '0;
         end
      endcase
   end

   always_comb begin
      clr_in  = clr_ff;
      p_in    = p_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      pend_in = pend_ff;
      bad_in  = bad_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + NODE_ONE;
         end
         ST_IDLE: begin
            pend_in = 1'b0;
            if (accept) begin
               if (req_op == OP_WRITE) begin
                  acc_in = req_value;
                  p_in   = leaf;
               end else begin
                  acc_in = '0;
                  bad_in = reversed;
                  a_in   = ptr_type'(lo_int + ELEMENTS);
                  b_in   = ptr_type'(hi_clamp + ELEMENTS + 1);
               end
            end
         end
         ST_W_UP: begin
            acc_in = sum_out;
            p_in   = parent;
         end
         ST_Q_LO: begin
            acc_in  = sum_out;
            pend_in = a_lt_b && a_ff[0];
            if (a_lt_b && a_ff[0]) a_in = a_ff + ptr_type'(1);
         end
         ST_Q_HI: begin
            acc_in  = sum_out;
            pend_in = b_ff[0];
            a_in    = a_ff >> 1;
            b_in    = b_ff >> 1;
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      bad_ff <= bad_in;
   end

   `RSST_ASSERT_IMPL(a_query_order, clock, reset, state_ff == ST_Q_HI, a_ff <= b_ff, "query bounds crossed mid-level")
   `RSST_ASSERT_IMPL(a_refresh_below_root, clock, reset, state_ff == ST_W_UP, p_ff > NODE_ONE, "refresh walked past the root")
   `RSST_ASSERT_IMPL(a_bad_gives_zero, clock, reset, result.valid && result.bad, result.sum == '0, "reversed range with nonzero sum")
   `RSST_ASSERT_NEXT(a_reversed_flagged, clock, reset, accept && (req_op == OP_QUERY) && reversed, (state_ff == ST_DONE) && bad_ff, "reversed range not flagged")

endmodule

// File: hdl/range_sum_segment_tree.sv
// Top level of the range-sum segment tree with point writes.
// Usage: request beats on req_* carry an op, two element indexes and a value. A write beat
// (op 0) stores one element and refreshes its ancestors; it gives no response. A query beat
// (op 1) gives one response beat on rsp_* with the wrapped sum of elements index_lo to
// index_hi inclusive; a reversed range returns zero with rsp_bad_range set.
// Timing: one shared adder and the single node memory read port set the pace. A write stores
// the leaf, then walks up in ST_W_UP, refreshing one ancestor per level up to the root. A query
// visits each level in an ST_Q_LO step and an ST_Q_HI step, then rsp_valid rises from the
// response register after ST_DONE; a reversed range goes straight from ST_IDLE to ST_DONE.
// The block returns to ST_IDLE at the edge that registers the response. req_stall is high
// while an item is being worked, so items are taken one at a time.
// Reset: a synchronous reset starts a clearing pass over all 2 * ELEMENTS node entries,
// 2048 here, during which req_stall stays high.
// Stalls: the response sits in an output register. While rsp_stall holds it, the block still
// takes new beats; a further query waits at its end until the register is free.
`timescale 1ns / 1ps
module range_sum_segment_tree (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic [rsst_pkg::IDX_W-1:0]        req_index_lo,
   input  logic [rsst_pkg::IDX_W-1:0]        req_index_hi,
   input  logic signed [rsst_pkg::SUM_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [rsst_pkg::SUM_W-1:0] rsp_range_sum,
   output logic                              rsp_bad_range
);
   import rsst_pkg::*;

   mem_req_type             mem_req;
   logic [SUM_W-1:0]        mem_rd_data;
   result_type              result;
   logic                    out_free;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic                    rsp_bad_ff, rsp_bad_in;

   // The response register is free when empty or when its beat leaves this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   rsst_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_index_lo (req_index_lo),
      .req_index_hi (req_index_hi),
      .req_value    (req_value),
      .mem_req      (mem_req),
      .mem_rd_data  (mem_rd_data),
      .out_free     (out_free),
      .result       (result)
   );

   rsst_node_ram u_ram (
      .clock      (clock),
      .mem_req    (mem_req),
      .rd_data_ff (mem_rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (result.valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = result.sum;
         rsp_bad_in   = result.bad;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sum_ff <= rsp_sum_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;
   assign rsp_bad_range = rsp_bad_ff;

endmodule
